FILE: rtl/core/fp64mm_pkg.sv
package fp64mm_pkg;

    localparam logic [2:0] CMD_LOAD_A = 3'd0;
    localparam logic [2:0] CMD_LOAD_B = 3'd1;
    localparam logic [2:0] CMD_LOAD_C = 3'd2;
    localparam logic [2:0] CMD_MAC    = 3'd3;
    localparam logic [2:0] CMD_READ_C = 3'd4;

    localparam logic [1:0] ACK_LOAD = 2'd0;
    localparam logic [1:0] ACK_MAC  = 2'd1;
    localparam logic [1:0] ACK_READ = 2'd2;

    localparam logic [63:0] FP_QUIET  = 64'h0008_0000_0000_0000;
    localparam logic [63:0] FP_DEFNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] FP_INF    = 64'h7FF0_0000_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CRD,
        S_CLOAD,
        S_ABRD,
        S_START,
        S_WAIT
    } top_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL,
        F_SETUP,
        F_ALIGN,
        F_ADD,
        F_NORM,
        F_RSET,
        F_RSH,
        F_ROUND,
        F_DONE
    } fma_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } fma_in_t;

    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/fp64mm_ram.sv
module fp64mm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/fp64mm_fma.sv
module fp64mm_fma (
    input  logic               clk,
    input  logic               rst_n,
    input  fp64mm_pkg::fma_in_t req,
    output logic               done,
    output logic [63:0]        result
);
    import fp64mm_pkg::*;

    fma_state_t          fstate_reg, fstate_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next, mc_reg, mc_next;
    logic signed [13:0]  ea_reg, ea_next, eb_reg, eb_next, ec_reg, ec_next;
    logic                cz_reg, cz_next, sp_reg, sp_next, sc_reg, sc_next;
    logic [1:0]          step_reg, step_next;
    logic [105:0]        p_reg, p_next;
    logic [191:0]        w_reg, w_next, o_reg, o_next;
    logic                xsh_reg, xsh_next, st_reg, st_next, s_reg, s_next;
    logic signed [13:0]  e_reg, e_next, lsb_reg, lsb_next;
    logic [7:0]          cnt_reg, cnt_next, lz_reg, lz_next;
    logic [63:0]         res_reg, res_next;

    logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
    logic        spec_hit;
    logic [63:0] spec_val;
    logic        in_sp;

    logic [26:0]  sa, sb;
    logic [53:0]  prod;
    logic [105:0] pp;

    logic signed [13:0] ex, ey, diff;
    logic [5:0]         amt;
    logic [191:0]       mask, xv, yv, sum;
    logic [192:0]       dxy, dyx;
    logic               lost, x_eq_y;
    logic [5:0]         lzc;
    logic signed [13:0] lzs, tpos, rs, rs1;
    logic [53:0]        m0, m1, m2;
    logic signed [13:0] lsb2, biased;

    always_comb
    begin
        a_nan  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] != 52'd0);
        b_nan  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] != 52'd0);
        c_nan  = (req.c[62:52] == 11'h7FF) && (req.c[51:0] != 52'd0);
        a_inf  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] == 52'd0);
        b_inf  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] == 52'd0);
        c_inf  = (req.c[62:52] == 11'h7FF) && (req.c[51:0] == 52'd0);
        a_zero = req.a[62:0] == 63'd0;
        b_zero = req.b[62:0] == 63'd0;
        c_zero = req.c[62:0] == 63'd0;
        in_sp  = req.a[63] ^ req.b[63];
        spec_hit = 1'b1;
        spec_val = 64'd0;
        if (a_nan)
            spec_val = req.a | FP_QUIET;
        else if (b_nan)
            spec_val = req.b | FP_QUIET;
        else if (c_nan)
            spec_val = req.c | FP_QUIET;
        else if (a_inf || b_inf)
        begin
            if (a_zero || b_zero)
                spec_val = FP_DEFNAN;
            else if (c_inf && (req.c[63] != in_sp))
                spec_val = FP_DEFNAN;
            else
                spec_val = {in_sp, 63'd0} | FP_INF;
        end
        else if (c_inf)
            spec_val = req.c;
        else if (a_zero || b_zero)
        begin
            if (c_zero)
                spec_val = {in_sp & req.c[63], 63'd0};
            else
                spec_val = req.c;
        end
        else
            spec_hit = 1'b0;
    end

    always_comb
    begin
        sa   = step_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        sb   = step_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        prod = sa * sb;
        case ({1'b0, step_reg[1]} + {1'b0, step_reg[0]})
            2'd0:    pp = 106'(prod);
            2'd1:    pp = 106'(prod) << 27;
            2'd2:    pp = 106'(prod) << 54;
            default: pp = 106'd0;
        endcase

        ex   = ea_reg + eb_reg - 14'sd84;
        ey   = cz_reg ? ex : (ec_reg - 14'sd137);
        diff = (ex >= ey) ? (ex - ey) : (ey - ex);

        amt  = (cnt_reg > 8'd63) ? 6'd63 : cnt_reg[5:0];
        mask = (192'd1 << amt) - 192'd1;
        lost = |(w_reg & mask);

        xv     = xsh_reg ? (w_reg | {191'd0, st_reg}) : o_reg;
        yv     = xsh_reg ? o_reg : (w_reg | {191'd0, st_reg});
        sum    = xv + yv;
        dxy    = {1'b0, xv} - {1'b0, yv};
        dyx    = {1'b0, yv} - {1'b0, xv};
        x_eq_y = xv == yv;

        lzc  = lzc64(w_reg[191:128]);
        lzs  = $signed({6'd0, lz_reg});
        tpos = -14'sd1074 - e_reg + lzs;
        rs   = (tpos > 14'sd139) ? tpos : 14'sd139;
        rs1  = rs - 14'sd1;

        m0 = {1'b0, w_reg[53:1]};
        m1 = m0 + {53'd0, w_reg[0] & (st_reg | m0[0])};
        m2 = m1[53] ? (m1 >> 1) : m1;
        lsb2   = m1[53] ? (lsb_reg + 14'sd1) : lsb_reg;
        biased = lsb2 + 14'sd1075;
    end

    always_comb
    begin
        fstate_next = fstate_reg;
        case (fstate_reg)
            F_IDLE:
                if (req.start)
                    fstate_next = spec_hit ? F_DONE : F_MUL;
            F_MUL:
                if (step_reg == 2'd3)
                    fstate_next = F_SETUP;
            F_SETUP:
                fstate_next = F_ALIGN;
            F_ALIGN:
                if (cnt_reg == 8'd0)
                    fstate_next = F_ADD;
            F_ADD:
                if ((sp_reg != sc_reg) && x_eq_y)
                    fstate_next = F_DONE;
                else
                    fstate_next = F_NORM;
            F_NORM:
                if (w_reg[191:128] != 64'd0)
                    fstate_next = F_RSET;
            F_RSET:
                fstate_next = F_RSH;
            F_RSH:
                if (cnt_reg == 8'd0)
                    fstate_next = F_ROUND;
            F_ROUND:
                fstate_next = F_DONE;
            F_DONE:
                fstate_next = F_IDLE;
            default:
                fstate_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        mc_next   = mc_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        ec_next   = ec_reg;
        cz_next   = cz_reg;
        sp_next   = sp_reg;
        sc_next   = sc_reg;
        step_next = step_reg;
        p_next    = p_reg;
        w_next    = w_reg;
        o_next    = o_reg;
        xsh_next  = xsh_reg;
        st_next   = st_reg;
        s_next    = s_reg;
        e_next    = e_reg;
        lsb_next  = lsb_reg;
        cnt_next  = cnt_reg;
        lz_next   = lz_reg;
        res_next  = res_reg;
        case (fstate_reg)
            F_IDLE:
                if (req.start)
                begin
                    res_next  = spec_val;
                    ma_next   = {req.a[62:52] != 11'd0, req.a[51:0]};
                    mb_next   = {req.b[62:52] != 11'd0, req.b[51:0]};
                    mc_next   = {req.c[62:52] != 11'd0, req.c[51:0]};
                    ea_next   = (req.a[62:52] == 11'd0) ? -14'sd1074
                              : ($signed({3'd0, req.a[62:52]}) - 14'sd1075);
                    eb_next   = (req.b[62:52] == 11'd0) ? -14'sd1074
                              : ($signed({3'd0, req.b[62:52]}) - 14'sd1075);
                    ec_next   = (req.c[62:52] == 11'd0) ? -14'sd1074
                              : ($signed({3'd0, req.c[62:52]}) - 14'sd1075);
                    cz_next   = c_zero;
                    sp_next   = in_sp;
                    sc_next   = req.c[63];
                    step_next = 2'd0;
                    p_next    = 106'd0;
                end
            F_MUL:
            begin
                p_next    = p_reg + pp;
                step_next = step_reg + 2'd1;
            end
            F_SETUP:
            begin
                st_next  = 1'b0;
                cnt_next = (diff > 14'sd192) ? 8'd192 : diff[7:0];
                if (ex >= ey)
                begin
                    w_next   = cz_reg ? 192'd0 : {2'd0, mc_reg, 137'd0};
                    o_next   = {2'd0, p_reg, 84'd0};
                    xsh_next = 1'b0;
                    e_next   = ex;
                end
                else
                begin
                    w_next   = {2'd0, p_reg, 84'd0};
                    o_next   = cz_reg ? 192'd0 : {2'd0, mc_reg, 137'd0};
                    xsh_next = 1'b1;
                    e_next   = ey;
                end
            end
            F_ALIGN, F_RSH:
                if (cnt_reg != 8'd0)
                begin
                    w_next   = w_reg >> amt;
                    st_next  = st_reg | lost;
                    cnt_next = cnt_reg - {2'd0, amt};
                end
            F_ADD:
            begin
                lz_next = 8'd0;
                if (sp_reg == sc_reg)
                begin
                    w_next = sum;
                    s_next = sp_reg;
                end
                else if (x_eq_y)
                    res_next = 64'd0;
                else if (!dxy[192])
                begin
                    w_next = dxy[191:0];
                    s_next = sp_reg;
                end
                else
                begin
                    w_next = dyx[191:0];
                    s_next = sc_reg;
                end
            end
            F_NORM:
                if (w_reg[191:128] == 64'd0)
                begin
                    w_next  = w_reg << 64;
                    lz_next = lz_reg + 8'd64;
                end
                else
                begin
                    w_next  = w_reg << lzc;
                    lz_next = lz_reg + {2'd0, lzc};
                end
            F_RSET:
            begin
                st_next  = 1'b0;
                lsb_next = rs - lzs + e_reg;
                cnt_next = (rs1 > 14'sd192) ? 8'd192 : rs1[7:0];
            end
            F_ROUND:
                if (!m2[52])
                    res_next = {s_reg, 11'd0, m2[51:0]};
                else if (biased >= 14'sd2047)
                    res_next = {s_reg, 63'd0} | FP_INF;
                else
                    res_next = {s_reg, biased[10:0], m2[51:0]};
            default:
                res_next = res_reg;
        endcase
    end

    always_comb
    begin
        done   = fstate_reg == F_DONE;
        result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fstate_reg <= F_IDLE;
        else
            fstate_reg <= fstate_next;
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        mc_reg   <= mc_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ec_reg   <= ec_next;
        cz_reg   <= cz_next;
        sp_reg   <= sp_next;
        sc_reg   <= sc_next;
        step_reg <= step_next;
        p_reg    <= p_next;
        w_reg    <= w_next;
        o_reg    <= o_next;
        xsh_reg  <= xsh_next;
        st_reg   <= st_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        lsb_reg  <= lsb_next;
        cnt_reg  <= cnt_next;
        lz_reg   <= lz_next;
        res_reg  <= res_next;
    end

endmodule

FILE: rtl/core/fp64_matrix_multiply_accumulate.sv
// Channel | Direction | Handshake           | Contents
// s_      | in        | s_tvalid / s_tready | tuser cmd, tdata row, col, value
// m_      | out       | m_tvalid / m_tready | tuser ack_kind, tdata read_value
// cfg_    | in        | cfg_valid/cfg_ready | cfg_data size_in_use
//
// Loads and unused commands: acked in S_IDLE; C reads: S_READ (registered RAM read).
// Multiply-accumulate: per C element S_CRD and S_CLOAD, then n fused multiply-adds,
// each via S_ABRD, S_START and S_WAIT on the single iterative FMA unit (NaN, infinity
// or zero operands end at once; a cancelling sum skips normalization and rounding).
// s_tready is low while a command runs or while the result word is stalled.
// Asynchronous active-low reset clears control state and sets size_in_use to 16.
module fp64_matrix_multiply_accumulate #(
    parameter int DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // row[3:0], col[7:4], value[71:8]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // read_value[63:0]
    output logic [1:0]  m_tuser,   // ack_kind[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import fp64mm_pkg::*;

    localparam int AW = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int CW = $clog2(DIM + 1);

    function automatic logic [AW-1:0] idx(input int r, input int c);
        return AW'(r * DIM + c);
    endfunction

    top_state_t      state_reg, state_next;
    logic [4:0]      size_reg, size_next;
    logic [CW-1:0]   n_reg, n_next, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [63:0]     acc_reg, acc_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_kind_reg, out_kind_next;
    logic [63:0]     out_val_reg, out_val_next;

    logic [2:0]      in_cmd;
    logic [3:0]      in_row, in_col;
    logic [63:0]     in_value;
    logic            accept, in_ok;
    logic [AW-1:0]   in_idx, ij_idx;
    logic [CW-1:0]   n_eff;
    logic            last_i, last_j, last_k;

    logic            a_we, b_we, c_we;
    logic [AW-1:0]   c_waddr, c_raddr;
    logic [63:0]     c_wdata, a_rdata, b_rdata, c_rdata;

    fma_in_t         fma_req;
    logic            fma_done;
    logic [63:0]     fma_result;

    assign in_cmd   = s_tuser;
    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[71:8];

    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_val_reg;
    assign m_tuser   = out_kind_reg;

    assign in_ok  = (int'(in_row) < DIM) && (int'(in_col) < DIM);
    assign in_idx = idx(int'(in_row), int'(in_col));
    assign ij_idx = idx(int'(i_reg), int'(j_reg));
    assign n_eff  = (int'(size_reg) > DIM) ? CW'(DIM) : CW'(size_reg);
    assign last_i = i_reg == n_reg - CW'(1);
    assign last_j = j_reg == n_reg - CW'(1);
    assign last_k = k_reg == n_reg - CW'(1);

    assign a_we    = accept && (in_cmd == CMD_LOAD_A) && in_ok;
    assign b_we    = accept && (in_cmd == CMD_LOAD_B) && in_ok;
    assign c_we    = (accept && (in_cmd == CMD_LOAD_C) && in_ok)
                   || ((state_reg == S_WAIT) && fma_done && last_k);
    assign c_waddr = (state_reg == S_IDLE) ? in_idx : ij_idx;
    assign c_wdata = (state_reg == S_IDLE) ? in_value : fma_result;
    assign c_raddr = (state_reg == S_IDLE) ? in_idx : ij_idx;

    assign fma_req.start = state_reg == S_START;
    assign fma_req.a     = a_rdata;
    assign fma_req.b     = b_rdata;
    assign fma_req.c     = acc_reg;

    fp64mm_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (in_idx),
        .wdata (in_value),
        .raddr (idx(int'(i_reg), int'(k_reg))),
        .rdata (a_rdata)
    );

    fp64mm_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (in_idx),
        .wdata (in_value),
        .raddr (idx(int'(k_reg), int'(j_reg))),
        .rdata (b_rdata)
    );

    fp64mm_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    fp64mm_fma u_fma (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fma_req),
        .done   (fma_done),
        .result (fma_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    case (in_cmd)
                        CMD_READ_C: state_next = in_ok ? S_READ : S_IDLE;
                        CMD_MAC:    state_next = (n_eff == CW'(0)) ? S_IDLE : S_CRD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            S_READ:  state_next = S_IDLE;
            S_CRD:   state_next = S_CLOAD;
            S_CLOAD: state_next = S_ABRD;
            S_ABRD:  state_next = S_START;
            S_START: state_next = S_WAIT;
            S_WAIT:
                if (fma_done)
                begin
                    if (!last_k)
                        state_next = S_ABRD;
                    else if (last_i && last_j)
                        state_next = S_IDLE;
                    else
                        state_next = S_CRD;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        size_next      = cfg_valid ? cfg_data : size_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_val_next   = out_val_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    out_val_next = 64'd0;
                    case (in_cmd)
                        CMD_READ_C:
                            if (!in_ok)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ACK_READ;
                            end
                        CMD_MAC:
                        begin
                            n_next = n_eff;
                            i_next = CW'(0);
                            j_next = CW'(0);
                            k_next = CW'(0);
                            if (n_eff == CW'(0))
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ACK_MAC;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ACK_LOAD;
                        end
                    endcase
                end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = ACK_READ;
                out_val_next   = c_rdata;
            end
            S_CLOAD:
                acc_next = c_rdata;
            S_WAIT:
                if (fma_done)
                begin
                    acc_next = fma_result;
                    if (!last_k)
                        k_next = k_reg + CW'(1);
                    else
                    begin
                        k_next = CW'(0);
                        if (!last_j)
                            j_next = j_reg + CW'(1);
                        else
                        begin
                            j_next = CW'(0);
                            if (!last_i)
                                i_next = i_reg + CW'(1);
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ACK_MAC;
                                out_val_next   = 64'd0;
                            end
                        end
                    end
                end
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        out_kind_reg <= out_kind_next;
        out_val_reg  <= out_val_next;
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while a command runs");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fma_done |-> (state_reg == S_WAIT))
        else $error("FMA finished outside the wait state");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> ((k_reg < n_reg) && (i_reg < n_reg) && (j_reg < n_reg)))
        else $error("matrix index beyond size");

    a_out_free_on_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> !out_valid_reg)
        else $error("result word pending during multiply-accumulate");

endmodule

FILE: tb/sv/fp64_matrix_multiply_accumulate_test.sv
`timescale 1ns / 1ps

module fp64_matrix_multiply_accumulate_test;
    import fp64mm_pkg::*;

    localparam int STALL_LIMIT = 400000;

    class mac_scoreboard;
        logic [63:0] a_mem [256];
        logic [63:0] b_mem [256];
        logic [63:0] c_mem [256];
        int unsigned order;
        logic [65:0] pending [$];
        int errors;

        function new();
            order = 16;
            errors = 0;
        endfunction

        function bit is_nan(input logic [63:0] x);
            return x[62:52] == 11'h7FF && x[51:0] != 0;
        endfunction

        function bit is_inf(input logic [63:0] x);
            return x[62:52] == 11'h7FF && x[51:0] == 0;
        endfunction

        function bit is_zero(input logic [63:0] x);
            return x[62:0] == 0;
        endfunction

        function void unpack(input logic [63:0] x, output logic [63:0] m, output int e);
            if (x[62:52] == 0)
            begin
                m = {12'b0, x[51:0]};
                e = -1074;
                while (m < 64'h0010_0000_0000_0000)
                begin
                    m = m << 1;
                    e = e - 1;
                end
            end
            else
            begin
                m = {11'b0, 1'b1, x[51:0]};
                e = int'(x[62:52]) - 1075;
            end
        endfunction

        function bit shift_sticky(input logic [191:0] v, input int n, output logic [191:0] o);
            if (n >= 192)
            begin
                o = '0;
                return |v;
            end
            o = v >> n;
            return |(v & ((192'd1 << n) - 192'd1));
        endfunction

        function logic [63:0] fused_madd(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] c);
            logic [63:0] ma, mb, mc, m;
            logic [127:0] prod;
            logic [191:0] xv, yv, rv, tv;
            int ea, eb, ec, ex, ey, ee, t, sh, lsb, biased;
            bit st, rb;
            logic sp, sc, s;
            sp = a[63] ^ b[63];
            sc = c[63];
            if (is_nan(a)) return a | FP_QUIET;
            if (is_nan(b)) return b | FP_QUIET;
            if (is_nan(c)) return c | FP_QUIET;
            if (is_inf(a) || is_inf(b))
            begin
                if (is_zero(a) || is_zero(b)) return FP_DEFNAN;
                if (is_inf(c) && sc != sp) return FP_DEFNAN;
                return {sp, FP_INF[62:0]};
            end
            if (is_inf(c)) return c;
            if (is_zero(a) || is_zero(b))
            begin
                if (is_zero(c)) return {sp & sc, 63'b0};
                return c;
            end
            unpack(a, ma, ea);
            unpack(b, mb, eb);
            prod = {64'b0, ma} * {64'b0, mb};
            xv = {64'b0, prod} << 84;
            ex = ea + eb - 84;
            if (is_zero(c))
            begin
                yv = '0;
                ey = ex;
            end
            else
            begin
                unpack(c, mc, ec);
                yv = {128'b0, mc} << 137;
                ey = ec - 137;
            end
            if (ex >= ey)
            begin
                st = shift_sticky(yv, ex - ey, tv);
                yv = tv | 192'(st);
                ee = ex;
            end
            else
            begin
                st = shift_sticky(xv, ey - ex, tv);
                xv = tv | 192'(st);
                ee = ey;
            end
            if (sp == sc)
            begin
                rv = xv + yv;
                s = sp;
            end
            else if (xv == yv)
                return 64'b0;
            else if (xv > yv)
            begin
                rv = xv - yv;
                s = sp;
            end
            else
            begin
                rv = yv - xv;
                s = sc;
            end
            t = -1;
            for (int i = 191; i >= 0; i--)
            begin
                if (t < 0 && rv[i])
                    t = i;
            end
            if (t < 0) return 64'b0;
            sh = t - 52;
            if (sh < -1074 - ee) sh = -1074 - ee;
            lsb = sh + ee;
            if (sh <= 0)
                m = rv[63:0] << (-sh);
            else
            begin
                st = shift_sticky(rv, sh - 1, tv);
                rb = tv[0];
                m = tv[64:1];
                if (rb && (st || m[0])) m = m + 1;
                if (m == 64'h0020_0000_0000_0000)
                begin
                    m = m >> 1;
                    lsb = lsb + 1;
                end
            end
            if (m < 64'h0010_0000_0000_0000) return {s, m[62:0]};
            biased = lsb + 1075;
            if (biased >= 2047) return {s, FP_INF[62:0]};
            return {s, biased[10:0], m[51:0]};
        endfunction

        function void note(input logic [2:0] cmd, input logic [3:0] row, input logic [3:0] col,
                           input logic [63:0] val);
            int idx, n;
            logic [63:0] acc;
            idx = int'(row) * 16 + int'(col);
            case (cmd)
                CMD_LOAD_A: begin a_mem[idx] = val; pending.push_back({ACK_LOAD, 64'b0}); end
                CMD_LOAD_B: begin b_mem[idx] = val; pending.push_back({ACK_LOAD, 64'b0}); end
                CMD_LOAD_C: begin c_mem[idx] = val; pending.push_back({ACK_LOAD, 64'b0}); end
                CMD_MAC:
                begin
                    n = order > 16 ? 16 : order;
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                        begin
                            acc = c_mem[i * 16 + j];
                            for (int k = 0; k < n; k++)
                                acc = fused_madd(a_mem[i * 16 + k], b_mem[k * 16 + j], acc);
                            c_mem[i * 16 + j] = acc;
                        end
                    pending.push_back({ACK_MAC, 64'b0});
                end
                CMD_READ_C: pending.push_back({ACK_READ, c_mem[idx]});
                default: pending.push_back({ACK_LOAD, 64'b0});
            endcase
        endfunction

        task report(input string what, input logic [63:0] got, input logic [63:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(input logic [1:0] kind, input logic [63:0] data);
            logic [65:0] exp_word;
            if (pending.size() == 0)
            begin
                report("unexpected word", {62'b0, kind}, 64'b0);
                return;
            end
            exp_word = pending.pop_front();
            if (kind != exp_word[65:64]) report("ack_kind", {62'b0, kind}, {62'b0, exp_word[65:64]});
            if (data != exp_word[63:0]) report("read_value", data, exp_word[63:0]);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    mac_scoreboard sb;
    int snd_idle;
    int rcv_stall;
    int stall_count;
    int items;
    bit wa [256];
    bit wb [256];
    bit wc [256];

    fp64_matrix_multiply_accumulate #(.DIM(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tuser, m_tdata);
        m_tready <= ($urandom_range(0, 99) >= rcv_stall);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)))
            stall_count <= 0;
        else if (rst_n)
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand_fp();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 7))
                    0: v = 64'h0;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = FP_INF;
                    3: v = 64'hFFF0_0000_0000_0000;
                    4: v = 64'h7FF8_0000_0000_1234;
                    5: v = 64'hFFF0_0000_0000_0001;
                    6: v = 64'h7FEF_FFFF_FFFF_FFFF;
                    default: v = 64'h0000_0000_0000_0001;
                endcase
            end
            1: v = {$urandom, $urandom};
            2: v = {$urandom_range(0, 1) == 1, 11'b0, 20'($urandom), $urandom};
            default: v = {$urandom_range(0, 1) == 1, 11'($urandom_range(1003, 1043)),
                          20'($urandom), $urandom};
        endcase
        return v;
    endfunction

    task send(input logic [2:0] cmd, input logic [3:0] row, input logic [3:0] col,
              input logic [63:0] val);
        if ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {val, col, row};
        do @(posedge clk); while (!s_tready);
        sb.note(cmd, row, col, val);
        items++;
        case (cmd)
            CMD_LOAD_A: wa[int'(row) * 16 + int'(col)] = 1'b1;
            CMD_LOAD_B: wb[int'(row) * 16 + int'(col)] = 1'b1;
            CMD_LOAD_C: wc[int'(row) * 16 + int'(col)] = 1'b1;
            default: ;
        endcase
    endtask

    task drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task set_order(input logic [4:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.order = n;
    endtask

    function automatic bit mac_ready(input int n);
        int m;
        m = n > 16 ? 16 : n;
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
                if (!wa[i * 16 + j] || !wb[i * 16 + j] || !wc[i * 16 + j]) return 0;
        return 1;
    endfunction

    task read_written();
        int idx;
        idx = $urandom_range(0, 255);
        while (!wc[idx]) idx = $urandom_range(0, 255);
        send(CMD_READ_C, 4'(idx / 16), 4'(idx % 16), {$urandom, $urandom});
    endtask

    task single_case(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
        send(CMD_LOAD_A, 0, 0, a);
        send(CMD_LOAD_B, 0, 0, b);
        send(CMD_LOAD_C, 0, 0, c);
        send(CMD_MAC, 0, 0, 64'b0);
        send(CMD_READ_C, 0, 0, 64'b0);
    endtask

    task mac_sequence(input int n, input bit nice);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                send(CMD_LOAD_A, 4'(i), 4'(j), nice ? rand_fp() | 64'h3000_0000_0000_0000 : rand_fp());
                send(CMD_LOAD_B, 4'(i), 4'(j), rand_fp());
                send(CMD_LOAD_C, 4'(i), 4'(j), rand_fp());
            end
        send(CMD_MAC, 4'($urandom), 4'($urandom), {$urandom, $urandom});
        repeat ($urandom_range(1, 4)) read_written();
    endtask

    initial
    begin
        int n;
        sb = new();
        snd_idle = 7;
        rcv_stall = 52;
        stall_count = 0;
        items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_order(5'd1);
        single_case(64'h7FF0_0000_0000_0001, 64'h7FF8_0000_0000_0002, 64'h3FF0_0000_0000_0000);
        single_case(FP_INF, 64'h8000_0000_0000_0000, 64'h0);
        single_case(FP_INF, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        single_case(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
        single_case(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0);
        single_case(64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'h8000_0000_0000_0000);
        for (int k = 1; k <= 3; k++)
            send(3'(CMD_READ_C + k), 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(CMD_LOAD_C, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(CMD_READ_C, 4'hF, 4'hF, 64'h0);
        set_order(5'd0);
        send(CMD_MAC, 0, 0, 64'b0);
        send(CMD_READ_C, 0, 0, 64'b0);

        while (items < 180)
        begin
            if (items > 100 && snd_idle == 7)
            begin
                drain();
                snd_idle = 52;
                rcv_stall = 7;
            end
            if ($urandom_range(0, 99) < 60)
            begin
                n = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
                set_order(5'(n));
                mac_sequence(n, 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: send(3'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), {$urandom, $urandom});
                    1: send(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), {$urandom, $urandom});
                    2: read_written();
                    default:
                        if (mac_ready(sb.order)) send(CMD_MAC, 4'($urandom), 4'($urandom), 64'b0);
                endcase
            end
        end

        drain();
        snd_idle = 0;
        rcv_stall = 0;
        set_order(5'd31);
        mac_sequence(16, 1'b1);
        repeat (10) read_written();

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
